FILE: src/lsmf_pkg.sv
package lsmf_pkg;

    localparam int TAG_BITS   = 64;
    localparam int AGENT_BITS = 4;

    // agent field on the wire is four bits; only the low AGENT_USED bits of it are kept
    localparam int AGENT_USED = (AGENT_BITS < 4) ? AGENT_BITS : 4;
    localparam logic [3:0] AGENT_MASK = 4'((1 << AGENT_USED) - 1);

    typedef enum logic [1:0] {
        MODE_APPLY = 2'd0,
        MODE_BEGIN = 2'd1,
        MODE_TRACK = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        MSG_WELCOME = 3'd0,
        MSG_CATALOG = 3'd1,
        MSG_FOCUS   = 3'd2,
        MSG_STATS   = 3'd3,
        MSG_ACK     = 3'd4,
        MSG_NOTICE  = 3'd5,
        MSG_PING    = 3'd6,
        MSG_OTHER   = 3'd7
    } t_msg;

    typedef enum logic [1:0] {
        VD_IGNORED  = 2'd0,
        VD_APPLIED  = 2'd1,
        VD_BUFFERED = 2'd2
    } t_verdict;

    localparam int FL_CATALOG = 0;
    localparam int FL_FOCUS   = 1;
    localparam int FL_STATS   = 2;
    localparam int FL_NOTICE  = 3;
    localparam int FL_PING    = 4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  msg_type;
        logic        has_link;
        logic [63:0] link_tag;
        logic [31:0] seq_num;
        logic [31:0] sel_rev;
        logic [3:0]  agent_num;
        logic [63:0] action_tag;
        logic [7:0]  ack_status;
        logic [31:0] payload_word;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [1:0]  link_phase;
        logic [3:0]  current_agent;
        logic [31:0] current_rev;
        logic [4:0]  valid_flags;
        logic        action_waiting;
        logic [31:0] focus_word;
        logic [31:0] stats_word;
        logic [31:0] ping_ms;
    } t_out_word;

    // one buffered focus or stats body
    typedef struct packed {
        logic        vld;
        logic [31:0] rev;
        logic [3:0]  agent;
        logic [31:0] word;
    } t_slot;

endpackage

FILE: src/lsmf_chan_if.sv
interface lsmf_in_if
    import lsmf_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lsmf_out_if
    import lsmf_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/link_session_message_filter_top.sv
// channel   modport  word          handshake
// i_in      sink     t_in_word     valid/ready, taken when both high
// o_out     source   t_out_word    valid/ready, taken when both high
//
// One word per cycle sustained while o_out accepts; o_out.valid rises once the result register is loaded.
// Words pass an input register, then the session logic updates its state and
// loads the result register in the same cycle.
// i_rst_n is synchronous, active low; the link comes up in the link-down phase.
// A stall on o_out fills the input register, then drops i_in.ready.
module link_session_message_filter_top
    import lsmf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    lsmf_in_if.sink   i_in,
    lsmf_out_if.source o_out
);

    logic      r_s1_vld;
    t_in_word  r_s1_word;
    logic      r_out_vld;
    t_out_word r_out_word;
    t_out_word res;
    logic      out_free;
    logic      fire;

    assign out_free   = !r_out_vld || o_out.ready;
    assign fire       = r_s1_vld && out_free;
    assign i_in.ready = !r_s1_vld || out_free;

    lsmf_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_word  (r_s1_word),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_s1_vld <= 1'b1;
            end else if (fire) begin
                r_s1_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_word <= i_in.payload;
        end
        if (fire) begin
            r_out_word <= res;
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.payload = r_out_word;

endmodule

FILE: src/lsmf_core.sv
module lsmf_core
    import lsmf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_word  i_word,
    output t_out_word o_res
);

    typedef enum logic [1:0] {
        PH_DOWN   = 2'd0,
        PH_HAND   = 2'd1,
        PH_ONLINE = 2'd2
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [TAG_BITS-1:0]   r_bound, n_bound;
    logic [31:0]           r_last_seq, n_last_seq;
    logic [3:0]            r_agent, n_agent;
    logic [31:0]           r_rev, n_rev;
    logic [4:0]            r_flags, n_flags;
    logic [31:0]           r_focus, n_focus;
    logic [31:0]           r_stats, n_stats;
    logic [31:0]           r_ping, n_ping;
    t_slot                 r_fslot, n_fslot;
    t_slot                 r_sslot, n_sslot;
    logic                  r_track_vld, n_track_vld;
    logic [TAG_BITS-1:0]   r_track_tag, n_track_tag;

    logic [TAG_BITS-1:0]   link_in;
    logic [TAG_BITS-1:0]   act_in;
    logic [3:0]            agent_in;
    logic                  link_ok;
    t_verdict              verdict;

    assign link_in  = i_word.link_tag[TAG_BITS-1:0];
    assign act_in   = i_word.action_tag[TAG_BITS-1:0];
    assign agent_in = i_word.agent_num & AGENT_MASK;
    assign link_ok  = i_word.has_link && (link_in == r_bound)
                      && (i_word.seq_num > r_last_seq);

    always_comb begin
        n_phase     = r_phase;
        n_bound     = r_bound;
        n_last_seq  = r_last_seq;
        n_agent     = r_agent;
        n_rev       = r_rev;
        n_flags     = r_flags;
        n_focus     = r_focus;
        n_stats     = r_stats;
        n_ping      = r_ping;
        n_fslot     = r_fslot;
        n_sslot     = r_sslot;
        n_track_vld = r_track_vld;
        n_track_tag = r_track_tag;
        verdict     = VD_IGNORED;

        case (i_word.mode)
            MODE_APPLY: begin
                case (r_phase)
                    PH_HAND: begin
                        if (i_word.msg_type == MSG_WELCOME && i_word.has_link
                            && i_word.seq_num == 32'd1) begin
                            n_bound     = link_in;
                            n_last_seq  = i_word.seq_num;
                            n_phase     = PH_ONLINE;
                            n_agent     = agent_in;
                            n_rev       = i_word.sel_rev;
                            n_flags     = r_flags & 5'(1 << FL_CATALOG);
                            n_fslot.vld = 1'b0;
                            n_sslot.vld = 1'b0;
                            n_track_vld = 1'b0;
                            verdict     = VD_APPLIED;
                        end
                    end
                    PH_ONLINE: begin
                        if (link_ok) begin
                            n_last_seq = i_word.seq_num;
                            case (i_word.msg_type)
                                MSG_CATALOG: begin
                                    n_flags[FL_CATALOG] = 1'b1;
                                    verdict = VD_APPLIED;
                                end
                                MSG_FOCUS: begin
                                    if (i_word.sel_rev > r_rev) begin
                                        n_fslot = {1'b1, i_word.sel_rev, agent_in,
                                                   i_word.payload_word};
                                        verdict = VD_BUFFERED;
                                    end else if (i_word.sel_rev == r_rev
                                                 && agent_in == r_agent) begin
                                        n_focus = i_word.payload_word;
                                        n_flags[FL_FOCUS] = 1'b1;
                                        verdict = VD_APPLIED;
                                    end
                                end
                                MSG_STATS: begin
                                    if (i_word.sel_rev > r_rev) begin
                                        n_sslot = {1'b1, i_word.sel_rev, agent_in,
                                                   i_word.payload_word};
                                        verdict = VD_BUFFERED;
                                    end else if (i_word.sel_rev == r_rev
                                                 && agent_in == r_agent) begin
                                        n_stats = i_word.payload_word;
                                        n_flags[FL_STATS] = 1'b1;
                                        verdict = VD_APPLIED;
                                    end
                                end
                                MSG_ACK: begin
                                    if (r_track_vld && act_in == r_track_tag) begin
                                        n_track_vld = 1'b0;
                                        n_fslot.vld = 1'b0;
                                        n_sslot.vld = 1'b0;
                                        verdict     = VD_APPLIED;
                                        if (i_word.ack_status == 8'd0) begin
                                            n_agent = agent_in;
                                            n_rev   = i_word.sel_rev;
                                            // promote slots that match the new selection
                                            if (r_fslot.vld && r_fslot.rev == i_word.sel_rev
                                                && r_fslot.agent == agent_in) begin
                                                n_focus = r_fslot.word;
                                                n_flags[FL_FOCUS] = 1'b1;
                                            end
                                            if (r_sslot.vld && r_sslot.rev == i_word.sel_rev
                                                && r_sslot.agent == agent_in) begin
                                                n_stats = r_sslot.word;
                                                n_flags[FL_STATS] = 1'b1;
                                            end
                                        end
                                    end
                                end
                                MSG_NOTICE: begin
                                    n_flags[FL_NOTICE] = 1'b1;
                                    verdict = VD_APPLIED;
                                end
                                MSG_PING: begin
                                    n_ping = i_word.payload_word;
                                    n_flags[FL_PING] = 1'b1;
                                    verdict = VD_APPLIED;
                                end
                                default: verdict = VD_IGNORED;
                            endcase
                        end
                    end
                    default: verdict = VD_IGNORED;
                endcase
            end
            MODE_BEGIN: begin
                // selection survives, everything else of the link goes
                n_phase     = PH_HAND;
                n_bound     = '0;
                n_last_seq  = '0;
                n_flags     = '0;
                n_focus     = '0;
                n_stats     = '0;
                n_ping      = '0;
                n_fslot.vld = 1'b0;
                n_sslot.vld = 1'b0;
                n_track_vld = 1'b0;
                verdict     = VD_APPLIED;
            end
            MODE_TRACK: begin
                n_track_vld = 1'b1;
                n_track_tag = act_in;
                verdict     = VD_APPLIED;
            end
            default: verdict = VD_IGNORED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DOWN;
            r_bound     <= '0;
            r_last_seq  <= '0;
            r_agent     <= '0;
            r_rev       <= '0;
            r_flags     <= '0;
            r_focus     <= '0;
            r_stats     <= '0;
            r_ping      <= '0;
            r_fslot     <= '0;
            r_sslot     <= '0;
            r_track_vld <= 1'b0;
            r_track_tag <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_bound     <= n_bound;
            r_last_seq  <= n_last_seq;
            r_agent     <= n_agent;
            r_rev       <= n_rev;
            r_flags     <= n_flags;
            r_focus     <= n_focus;
            r_stats     <= n_stats;
            r_ping      <= n_ping;
            r_fslot     <= n_fslot;
            r_sslot     <= n_sslot;
            r_track_vld <= n_track_vld;
            r_track_tag <= n_track_tag;
        end
    end

    assign o_res.verdict        = verdict;
    assign o_res.link_phase     = n_phase;
    assign o_res.current_agent  = n_agent;
    assign o_res.current_rev    = n_rev;
    assign o_res.valid_flags    = n_flags;
    assign o_res.action_waiting = n_track_vld;
    assign o_res.focus_word     = n_focus;
    assign o_res.stats_word     = n_stats;
    assign o_res.ping_ms        = n_ping;

    a_begin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_word.mode == MODE_BEGIN) |=>
            (r_phase == PH_HAND && r_flags == 5'd0 && !r_track_vld))
        else $error("begin handshake did not clear the link");

    a_down_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DOWN) |-> (r_flags == 5'd0 && !r_fslot.vld && !r_sslot.vld))
        else $error("link down with live flags or buffers");

    a_never_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_DOWN) |=> (r_phase != PH_DOWN))
        else $error("phase fell back to link down");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_last_seq) && $stable(r_flags) && $stable(r_rev)))
        else $error("state moved without a word");

endmodule

FILE: verif/session_check_pkg.sv
`timescale 1ns / 100ps

package session_check_pkg;
    import lsmf_pkg::*;

    // link phases as reported on link_phase
    localparam logic [1:0] LINK_IDLE      = 2'd0;
    localparam logic [1:0] LINK_HANDSHAKE = 2'd1;
    localparam logic [1:0] LINK_ONLINE    = 2'd2;

    // mode code the block must treat as a no-op
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int FOCUS_IDX = 0;
    localparam int STATS_IDX = 1;

    localparam logic [63:0] TAG_KEEP = {64{1'b1}} >> (64 - TAG_BITS);

    class session_scoreboard;
        t_out_word   expected_q[$];
        int          errors;
        int          words_in;
        int          results_seen;
        int          acted;
        int          ignored;
        int          buffered;
        int          sessions;

        // predicted session state
        logic [1:0]  phase;
        logic [63:0] bound_link;
        logic [31:0] last_seq;
        logic [3:0]  agent;
        logic [31:0] rev;
        logic [4:0]  flags;
        logic [31:0] body_word[2];
        logic [31:0] ping_word;
        t_slot       held[2];
        logic        track_on;
        logic [63:0] track_tag;

        function new();
            errors       = 0;
            words_in     = 0;
            results_seen = 0;
            acted        = 0;
            ignored      = 0;
            buffered     = 0;
            sessions     = 0;
            phase        = LINK_IDLE;
            agent        = '0;
            rev          = '0;
            drop_link();
        endfunction

        // everything but the selection goes
        function void drop_link();
            bound_link           = '0;
            last_seq             = '0;
            flags                = '0;
            body_word[FOCUS_IDX] = '0;
            body_word[STATS_IDX] = '0;
            ping_word            = '0;
            held[FOCUS_IDX]      = '0;
            held[STATS_IDX]      = '0;
            track_on             = 1'b0;
            track_tag            = '0;
        endfunction

        function int body_flag(int k);
            return (k == FOCUS_IDX) ? FL_FOCUS : FL_STATS;
        endfunction

        function t_verdict take_body(int k, logic [31:0] r, logic [3:0] a, logic [31:0] word);
            if (r < rev)
                return VD_IGNORED;
            if (r > rev) begin
                held[k] = '{1'b1, r, a, word};
                return VD_BUFFERED;
            end
            if (a != agent)
                return VD_IGNORED;
            body_word[k]       = word;
            flags[body_flag(k)] = 1'b1;
            return VD_APPLIED;
        endfunction

        function void promote(int k);
            if (held[k].vld && held[k].rev == rev && held[k].agent == agent) begin
                body_word[k]       = held[k].word;
                flags[body_flag(k)] = 1'b1;
            end
            held[k].vld = 1'b0;
        endfunction

        function t_verdict apply_word(t_in_word w);
            logic [63:0] link;
            logic [63:0] act;
            logic [3:0]  a;
            link = w.link_tag & TAG_KEEP;
            act  = w.action_tag & TAG_KEEP;
            a    = w.agent_num & AGENT_MASK;
            if (phase == LINK_HANDSHAKE) begin
                if (w.msg_type != MSG_WELCOME || !w.has_link || w.seq_num != 32'd1)
                    return VD_IGNORED;
                bound_link          = link;
                last_seq            = w.seq_num;
                phase               = LINK_ONLINE;
                agent               = a;
                rev                 = w.sel_rev;
                flags               = flags & (5'd1 << FL_CATALOG);
                held[FOCUS_IDX].vld = 1'b0;
                held[STATS_IDX].vld = 1'b0;
                track_on            = 1'b0;
                track_tag           = '0;
                sessions++;
                return VD_APPLIED;
            end
            if (phase != LINK_ONLINE || !w.has_link || link != bound_link)
                return VD_IGNORED;
            if (w.seq_num <= last_seq)
                return VD_IGNORED;
            // seq is taken even when the type then does nothing
            last_seq = w.seq_num;
            case (w.msg_type)
                MSG_CATALOG: begin
                    flags[FL_CATALOG] = 1'b1;
                    return VD_APPLIED;
                end
                MSG_FOCUS: return take_body(FOCUS_IDX, w.sel_rev, a, w.payload_word);
                MSG_STATS: return take_body(STATS_IDX, w.sel_rev, a, w.payload_word);
                MSG_ACK: begin
                    if (!track_on || act != track_tag)
                        return VD_IGNORED;
                    track_on  = 1'b0;
                    track_tag = '0;
                    if (w.ack_status == '0) begin
                        agent = a;
                        rev   = w.sel_rev;
                        promote(FOCUS_IDX);
                        promote(STATS_IDX);
                    end else begin
                        held[FOCUS_IDX].vld = 1'b0;
                        held[STATS_IDX].vld = 1'b0;
                    end
                    return VD_APPLIED;
                end
                MSG_NOTICE: begin
                    flags[FL_NOTICE] = 1'b1;
                    return VD_APPLIED;
                end
                MSG_PING: begin
                    ping_word      = w.payload_word;
                    flags[FL_PING] = 1'b1;
                    return VD_APPLIED;
                end
                default: return VD_IGNORED;
            endcase
        endfunction

        function void note_input(t_in_word w);
            t_out_word e;
            t_verdict  v;
            words_in++;
            case (w.mode)
                MODE_APPLY: v = apply_word(w);
                MODE_BEGIN: begin
                    drop_link();
                    phase = LINK_HANDSHAKE;
                    v     = VD_APPLIED;
                end
                MODE_TRACK: begin
                    track_tag = w.action_tag & TAG_KEEP;
                    track_on  = 1'b1;
                    v         = VD_APPLIED;
                end
                default: v = VD_IGNORED;
            endcase
            if (v == VD_IGNORED)
                ignored++;
            else
                acted++;
            if (v == VD_BUFFERED)
                buffered++;
            e.verdict        = v;
            e.link_phase     = phase;
            e.current_agent  = agent;
            e.current_rev    = rev;
            e.valid_flags    = flags;
            e.action_waiting = track_on;
            e.focus_word     = body_word[FOCUS_IDX];
            e.stats_word     = body_word[STATS_IDX];
            e.ping_ms        = ping_word;
            expected_q.push_back(e);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= 40)
                $display("tb_top: mismatch on %s at result %0d: got %h, expected %h",
                         what, results_seen, got, want);
        endtask

        task check_result(t_out_word got);
            t_out_word e;
            results_seen++;
            if (expected_q.size() == 0) begin
                report("result with nothing expected", got.verdict, '0);
                return;
            end
            e = expected_q.pop_front();
            if (got.verdict !== e.verdict)
                report("verdict", got.verdict, e.verdict);
            if (got.link_phase !== e.link_phase)
                report("link_phase", got.link_phase, e.link_phase);
            if (got.current_agent !== e.current_agent)
                report("current_agent", got.current_agent, e.current_agent);
            if (got.current_rev !== e.current_rev)
                report("current_rev", got.current_rev, e.current_rev);
            if (got.valid_flags !== e.valid_flags)
                report("valid_flags", got.valid_flags, e.valid_flags);
            if (got.action_waiting !== e.action_waiting)
                report("action_waiting", got.action_waiting, e.action_waiting);
            if (got.focus_word !== e.focus_word)
                report("focus_word", got.focus_word, e.focus_word);
            if (got.stats_word !== e.stats_word)
                report("stats_word", got.stats_word, e.stats_word);
            if (got.ping_ms !== e.ping_ms)
                report("ping_ms", got.ping_ms, e.ping_ms);
        endtask
    endclass

endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import lsmf_pkg::*;
    import session_check_pkg::*;

    localparam int          WORD_TARGET  = 1000;
    localparam int          HOLD_AT      = 400;
    localparam int          HOLD_CYCLES  = 150;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [31:0] SEQ_CEILING  = 32'hFFFF_FF00;
    localparam logic [63:0] LINK_A       = {64{1'b1}};
    localparam logic [31:0] REV_TOP      = 32'hFFFF_FFFE;

    logic i_clk;
    logic i_rst_n;

    lsmf_in_if  in_ch ();
    lsmf_out_if out_ch ();

    link_session_message_filter_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    session_scoreboard sb;
    bit hold_req;
    int tx_count;
    bit tx_idle;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic send_word(input t_in_word w);
        int gap;
        if (tx_count % 40 == 0)
            tx_idle = ($urandom_range(0, 3) != 0);
        tx_count++;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(w);
        if (sb.words_in == HOLD_AT)
            hold_req = 1'b1;
    endtask

    task automatic drain_results();
        int n;
        int stall;
        bit idle_on;
        n = 0;
        forever begin
            if (n % 40 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            n++;
            stall = idle_on ? $urandom_range(0, 15) : 0;
            // one long hold so the block backs up onto its input
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            sb.check_result(out_ch.payload);
        end
    endtask

    function automatic t_in_word msg_word(t_msg ty, logic [31:0] seq, logic [31:0] rev,
                                          logic [3:0] agent, logic [31:0] body);
        t_in_word w;
        w              = '0;
        w.mode         = MODE_APPLY;
        w.msg_type     = ty;
        w.has_link     = 1'b1;
        w.link_tag     = LINK_A;
        w.seq_num      = seq;
        w.sel_rev      = rev;
        w.agent_num    = agent;
        w.payload_word = body;
        return w;
    endfunction

    function automatic t_in_word ctrl_word(logic [1:0] m, logic [63:0] act);
        t_in_word w;
        w            = '0;
        w.mode       = m;
        w.action_tag = act;
        return w;
    endfunction

    task automatic run_directed();
        t_in_word w;
        // link down: nothing lands, but tracking does
        send_word(msg_word(MSG_PING, 32'd5, '0, '0, '1));
        send_word(ctrl_word(MODE_TRACK, '1));
        send_word(ctrl_word(MODE_UNUSED, '1));
        send_word(ctrl_word(MODE_BEGIN, '0));
        // handshaking: only a linked welcome with seq 1 gets through
        w = msg_word(MSG_WELCOME, 32'd1, REV_TOP, 4'hF, '0);
        w.has_link = 1'b0;
        send_word(w);
        send_word(msg_word(MSG_WELCOME, 32'd2, REV_TOP, 4'hF, '0));
        send_word(msg_word(MSG_CATALOG, 32'd1, REV_TOP, 4'hF, '0));
        send_word(msg_word(MSG_WELCOME, 32'd1, REV_TOP, 4'hF, '0));
        send_word(msg_word(MSG_CATALOG, 32'd2, '0, '0, '0));
        send_word(msg_word(MSG_PING, 32'd3, '0, '0, '1));
        send_word(msg_word(MSG_NOTICE, 32'd4, '0, '0, '0));
        send_word(msg_word(MSG_FOCUS, 32'd5, REV_TOP, 4'hF, 32'hA5A5_5A5A));
        send_word(msg_word(MSG_FOCUS, 32'd6, REV_TOP, 4'h0, 32'h1234_5678));
        send_word(msg_word(MSG_STATS, 32'd7, REV_TOP - 32'd1, 4'hF, '1));
        send_word(msg_word(MSG_STATS, 32'd8, '1, 4'hF, '1));
        send_word(msg_word(MSG_FOCUS, 32'd9, '1, 4'h0, 32'h5A5A_A5A5));
        send_word(msg_word(MSG_CATALOG, 32'd9, '0, '0, '0));
        w = msg_word(MSG_NOTICE, 32'd10, '0, '0, '0);
        w.link_tag = '0;
        send_word(w);
        send_word(msg_word(MSG_WELCOME, 32'd10, '0, '0, '0));
        send_word(msg_word(MSG_OTHER, 32'd11, '0, '0, '0));
        // rejected ack throws both held bodies away
        send_word(ctrl_word(MODE_TRACK, 64'h8000_0000_0000_0001));
        w = msg_word(MSG_ACK, 32'd12, '1, 4'h0, '0);
        w.action_tag = 64'h8000_0000_0000_0001;
        w.ack_status = 8'hFF;
        send_word(w);
        send_word(msg_word(MSG_STATS, 32'd13, '1, 4'h0, 32'hC3C3_3C3C));
        send_word(ctrl_word(MODE_TRACK, '1));
        send_word(msg_word(MSG_ACK, 32'd14, '1, 4'h0, '0));
        w = msg_word(MSG_ACK, 32'd15, '1, 4'h0, '0);
        w.action_tag = '1;
        send_word(w);
        send_word(msg_word(MSG_ACK, 32'd16, '1, 4'h0, '0));
        send_word(msg_word(MSG_PING, '1, '0, '0, 32'h0000_0001));
        send_word(ctrl_word(MODE_BEGIN, '0));
    endtask

    // mostly well-formed session traffic, a share of noise and damaged words
    function automatic t_in_word random_word();
        t_in_word w;
        int r;
        int t;
        int k;
        w.mode         = 2'($urandom_range(0, 3));
        w.msg_type     = 3'($urandom_range(0, 7));
        w.has_link     = 1'($urandom_range(0, 1));
        w.link_tag     = {$urandom(), $urandom()};
        w.seq_num      = $urandom();
        w.sel_rev      = $urandom();
        w.agent_num    = 4'($urandom_range(0, 15));
        w.action_tag   = {$urandom(), $urandom()};
        w.ack_status   = 8'($urandom_range(0, 255));
        w.payload_word = $urandom();
        r = $urandom_range(0, 99);
        if (r < 5)
            return w;
        if (r < 8 || sb.phase == LINK_IDLE || sb.last_seq > SEQ_CEILING) begin
            w.mode = MODE_BEGIN;
            return w;
        end
        if (r < 15) begin
            w.mode = MODE_TRACK;
            return w;
        end
        w.mode = MODE_APPLY;
        if (sb.phase == LINK_HANDSHAKE) begin
            if (r < 80) begin
                w.msg_type = MSG_WELCOME;
                w.has_link = 1'b1;
                w.seq_num  = 32'd1;
                if (r < 45)
                    w.sel_rev = $urandom_range(0, 7);
            end
            return w;
        end
        w.has_link = 1'b1;
        w.link_tag = (w.link_tag & ~TAG_KEEP) | sb.bound_link;
        w.seq_num  = sb.last_seq + $urandom_range(1, 4);
        if (r < 19)
            w.seq_num = sb.last_seq - $urandom_range(0, 2);
        else if (r < 22)
            w.link_tag ^= 64'd1 << $urandom_range(0, TAG_BITS - 1);
        t = $urandom_range(0, 15);
        case (t)
            0:               w.msg_type = MSG_WELCOME;
            1:               w.msg_type = MSG_OTHER;
            2:               w.msg_type = MSG_CATALOG;
            3:               w.msg_type = MSG_NOTICE;
            4:               w.msg_type = MSG_PING;
            5, 6, 7, 8:      w.msg_type = MSG_FOCUS;
            9, 10, 11, 12:   w.msg_type = MSG_STATS;
            default:         w.msg_type = MSG_ACK;
        endcase
        if (w.msg_type == MSG_FOCUS || w.msg_type == MSG_STATS) begin
            case ($urandom_range(0, 5))
                0:       w.sel_rev = sb.rev - 32'd1;
                1:       w.sel_rev = sb.rev + $urandom_range(1, 2);
                5:       ;
                default: w.sel_rev = sb.rev;
            endcase
            if ($urandom_range(0, 4) != 0)
                w.agent_num = sb.agent;
        end else if (w.msg_type == MSG_ACK) begin
            if ($urandom_range(0, 3) != 0)
                w.action_tag = (w.action_tag & ~TAG_KEEP) | sb.track_tag;
            if ($urandom_range(0, 2) != 0)
                w.ack_status = '0;
            k = $urandom_range(0, 2);
            if (k < 2 && sb.held[k].vld) begin
                w.sel_rev   = sb.held[k].rev;
                w.agent_num = sb.held[k].agent;
            end
        end
        return w;
    endfunction

    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        out_ch.ready  <= 1'b0;
        i_rst_n       <= 1'b0;
        hold_req = 1'b0;
        tx_count = 0;
        tx_idle  = 1'b0;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drain_results();
        join_none
        run_directed();
        while (sb.words_in < WORD_TARGET)
            send_word(random_word());
        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb_top: %0d words in, %0d results checked: %0d acted on, %0d buffered,",
                 sb.words_in, sb.results_seen, sb.acted, sb.buffered);
        $display("tb_top: %0d ignored, %0d sessions brought online, one %0d-cycle output hold",
                 sb.ignored, sb.sessions, HOLD_CYCLES);
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // no word moved on either side for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: no handshake for %0d cycles", quiet);
        $display("tb_top: errors");
        $finish;
    end

endmodule
